FILE: rtl/msort_pkg.sv
// Shared types and constants for the stable merge sorter.
// Holds record widths, controller state codes and the command/status structs.
// No dependencies.
`timescale 1ns / 1ps

package msort_pkg;

   // Default capacity of the record store
   localparam int MaxItems = 64;

   // Record layout: key in the low bits, tag above it
   localparam int KeyW = 32;
   localparam int TagW = 16;
   localparam int RecW = KeyW + TagW;

   // Controller states, one-hot
   typedef enum logic [3:0] {
      ST_LOAD  = 4'b0001,
      ST_SEG   = 4'b0010,
      ST_MERGE = 4'b0100,
      ST_SEND  = 4'b1000
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic store;       // input transfer, write record
      logic start_sort;  // last record taken, arm the first pass
      logic seg_load;    // set up one merge segment, fetch both heads
      logic merge;       // move one record into the destination bank
      logic emit_start;  // point the read side at sorted entry 0
      logic emit_next;   // result transfer done
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic sorted;      // merge width covers the whole set
      logic seg_end;     // current merge step writes the segment's last entry
      logic pass_end;    // current segment closes the pass
      logic emit_last;   // result being shown is the final one of the run
   } status_type;

endpackage

FILE: rtl/msort_ctrl.sv
// Controller state machine for the stable merge sorter.
// Sequences loading, merge segments and result output; uses msort_pkg.
`timescale 1ns / 1ps

module msort_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tlast,
   input  logic                   rsp_tready,
   input  msort_pkg::status_type  status,
   output msort_pkg::cmd_type     cmd,
   output logic                   req_tready,
   output logic                   rsp_tvalid
);

   msort_pkg::state_type state_ff, state_in;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         msort_pkg::ST_LOAD: begin
            cmd.store = req_tvalid;
            if (req_tvalid && req_tlast) begin
               cmd.start_sort = 1'b1;
               state_in       = msort_pkg::ST_SEG;
            end
         end
         msort_pkg::ST_SEG: begin
            if (status.sorted) begin
               cmd.emit_start = 1'b1;
               state_in       = msort_pkg::ST_SEND;
            end else begin
               cmd.seg_load = 1'b1;
               state_in     = msort_pkg::ST_MERGE;
            end
         end
         msort_pkg::ST_MERGE: begin
            cmd.merge = 1'b1;
            if (status.seg_end) begin
               state_in = msort_pkg::ST_SEG;
            end
         end
         msort_pkg::ST_SEND: begin
            if (rsp_tready) begin
               cmd.emit_next = 1'b1;
               if (status.emit_last) begin
                  state_in = msort_pkg::ST_LOAD;
               end
            end
         end
         default: begin
            state_in = msort_pkg::ST_LOAD;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= msort_pkg::ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   // Handshakes follow the state
   assign req_tready = (state_ff == msort_pkg::ST_LOAD);
   assign rsp_tvalid = (state_ff == msort_pkg::ST_SEND);

endmodule

FILE: rtl/msort_dpath.sv
// Datapath of the stable merge sorter: two ping-pong record banks,
// merge pointers, record count and the order-select register; uses msort_pkg.
`timescale 1ns / 1ps

module msort_dpath #(
   parameter int MAX_ITEMS = msort_pkg::MaxItems
) (
   input  logic                        clock,
   input  logic                        reset,
   input  msort_pkg::cmd_type          cmd,
   input  logic                        csr_valid,
   input  logic                        csr_wdata,
   input  logic [msort_pkg::RecW-1:0]  req_rec,
   output msort_pkg::status_type       status,
   output logic [msort_pkg::RecW-1:0]  rsp_rec,
   output logic                        rsp_last,
   output logic                        rsp_dropped
);

   localparam int RecW   = msort_pkg::RecW;
   localparam int KeyW   = msort_pkg::KeyW;
   localparam int CountW = $clog2(MAX_ITEMS + 1);
   localparam int IdxW   = $clog2(MAX_ITEMS);
   localparam int SumW   = CountW + 3;

   // Record banks; a pass reads one and writes the other
   logic [RecW-1:0] bank0 [MAX_ITEMS];
   logic [RecW-1:0] bank1 [MAX_ITEMS];
   logic [RecW-1:0] rd0a_ff, rd0b_ff, rd1a_ff, rd1b_ff;

   logic [CountW-1:0] count_ff, count_in;
   logic              ovf_ff, ovf_in;
   logic              sort_by_tag_ff, sort_by_tag_in;
   logic [CountW:0]   w_ff, w_in;
   logic [CountW-1:0] lo_ff, lo_in;
   logic [CountW-1:0] mid_ff, mid_in;
   logic [CountW-1:0] hi_ff, hi_in;
   logic [CountW-1:0] l_ff, l_in;
   logic [CountW-1:0] r_ff, r_in;
   logic [CountW-1:0] k_ff, k_in;
   logic              src_ff, src_in;

   logic [RecW-1:0]   head_l, head_r, merged;
   logic              greater, take_r, room;
   logic [SumW-1:0]   lo_plus_w, lo_plus_2w, n_ext;
   logic [CountW-1:0] mid_calc, hi_calc;
   logic              we0, we1;
   logic [IdxW-1:0]   wa0;
   logic [RecW-1:0]   wd0;

   // Heads of the two runs come from the source bank
   assign head_l = src_ff ? rd1a_ff : rd0a_ff;
   assign head_r = src_ff ? rd1b_ff : rd0b_ff;

   // Strict compare keeps equal records in arrival order
   always_comb begin
      if (sort_by_tag_ff) begin
         greater = head_l[RecW-1:KeyW] > head_r[RecW-1:KeyW];
      end else begin
         greater = $signed(head_l[KeyW-1:0]) > $signed(head_r[KeyW-1:0]);
      end
   end

   assign take_r = (l_ff == mid_ff) || ((r_ff != hi_ff) && greater);
   assign merged = take_r ? head_r : head_l;
   assign room   = (count_ff < CountW'(MAX_ITEMS));

   // Segment bounds, clamped to the set size
   assign n_ext      = SumW'(count_ff);
   assign lo_plus_w  = SumW'(lo_ff) + SumW'(w_ff);
   assign lo_plus_2w = SumW'(lo_ff) + (SumW'(w_ff) << 1);
   assign mid_calc   = (lo_plus_w < n_ext) ? lo_plus_w[CountW-1:0] : count_ff;
   assign hi_calc    = (lo_plus_2w < n_ext) ? lo_plus_2w[CountW-1:0] : count_ff;

   // Status to the controller
   assign status.sorted    = (w_ff >= {1'b0, count_ff});
   assign status.seg_end   = ((k_ff + CountW'(1)) == hi_ff);
   assign status.pass_end  = (hi_ff == count_ff);
   assign status.emit_last = (l_ff == (count_ff - CountW'(1)));

   // Next values of counters and pointers
   always_comb begin
      count_in       = count_ff;
      ovf_in         = ovf_ff;
      sort_by_tag_in = sort_by_tag_ff;
      w_in           = w_ff;
      lo_in          = lo_ff;
      mid_in         = mid_ff;
      hi_in          = hi_ff;
      l_in           = l_ff;
      r_in           = r_ff;
      k_in           = k_ff;
      src_in         = src_ff;

      if (csr_valid) begin
         sort_by_tag_in = csr_wdata;
      end

      if (cmd.store) begin
         if (room) begin
            count_in = count_ff + CountW'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end

      if (cmd.start_sort) begin
         w_in   = (CountW + 1)'(1);
         lo_in  = '0;
         src_in = 1'b0;
      end

      if (cmd.seg_load) begin
         mid_in = mid_calc;
         hi_in  = hi_calc;
         l_in   = lo_ff;
         r_in   = mid_calc;
         k_in   = lo_ff;
      end

      if (cmd.merge) begin
         k_in = k_ff + CountW'(1);
         if (take_r) begin
            r_in = r_ff + CountW'(1);
         end else begin
            l_in = l_ff + CountW'(1);
         end
         if (status.seg_end) begin
            lo_in = hi_ff;
            if (status.pass_end) begin
               lo_in  = '0;
               w_in   = w_ff << 1;
               src_in = ~src_ff;
            end
         end
      end

      if (cmd.emit_start) begin
         l_in = '0;
      end

      // End of run returns the block to an empty set
      if (cmd.emit_next) begin
         if (status.emit_last) begin
            count_in = '0;
            ovf_in   = 1'b0;
         end else begin
            l_in = l_ff + CountW'(1);
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= '0;
         ovf_ff         <= 1'b0;
         sort_by_tag_ff <= 1'b0;
         w_ff           <= '0;
         lo_ff          <= '0;
         mid_ff         <= '0;
         hi_ff          <= '0;
         l_ff           <= '0;
         r_ff           <= '0;
         k_ff           <= '0;
         src_ff         <= 1'b0;
      end else begin
         count_ff       <= count_in;
         ovf_ff         <= ovf_in;
         sort_by_tag_ff <= sort_by_tag_in;
         w_ff           <= w_in;
         lo_ff          <= lo_in;
         mid_ff         <= mid_in;
         hi_ff          <= hi_in;
         l_ff           <= l_in;
         r_ff           <= r_in;
         k_ff           <= k_in;
         src_ff         <= src_in;
      end
   end

   // Bank write ports: loading fills bank 0, a pass writes the non-source bank
   assign we0 = (cmd.store && room) || (cmd.merge && src_ff);
   assign wa0 = cmd.store ? count_ff[IdxW-1:0] : k_ff[IdxW-1:0];
   assign wd0 = cmd.store ? req_rec : merged;
   assign we1 = cmd.merge && !src_ff;

   // Bank 0, read at the next left and right pointers
   always_ff @(posedge clock) begin
      if (we0) begin
         bank0[wa0] <= wd0;
      end
      rd0a_ff <= bank0[l_in[IdxW-1:0]];
      rd0b_ff <= bank0[r_in[IdxW-1:0]];
   end

   // Bank 1
   always_ff @(posedge clock) begin
      if (we1) begin
         bank1[k_ff[IdxW-1:0]] <= merged;
      end
      rd1a_ff <= bank1[l_in[IdxW-1:0]];
      rd1b_ff <= bank1[r_in[IdxW-1:0]];
   end

   // Result: left head walks the sorted bank during output
   assign rsp_rec     = head_l;
   assign rsp_last    = status.emit_last;
   assign rsp_dropped = ovf_ff;

endmodule

FILE: rtl/stable_merge_sorter.sv
// Stable merge sorter: collects a set of records and returns them in order.
// Channels: req_* takes records, one per transfer, while loading; rsp_* returns
// the sorted run, one record per transfer, tlast on the final one.
// csr_* writes sort_by_tag (0: signed key order, 1: unsigned tag order).
// Sorting: after the transfer with tlast the set of n records is sorted in
// ceil(log2 n) bottom-up passes; in a pass each merge segment is set up and
// then merged one record at a time, set by the single write port of the
// destination bank. Results then leave at one per cycle while rsp_tready is high.
// req_tready is low from the last record until the final result is taken.
// Records beyond MAX_ITEMS are discarded; rsp_tuser flags every result of
// such a set. A stalled receiver simply holds the current result.
// Reset empties the set, clears the drop flag and selects key order; the
// record banks are not cleared and need no clearing pass.
// Depends on msort_pkg, msort_ctrl and msort_dpath.
`timescale 1ns / 1ps

module stable_merge_sorter #(
   parameter int MAX_ITEMS = msort_pkg::MaxItems
) (
   input  logic                        clock,
   input  logic                        reset,
   // config write
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic                        csr_wdata,   // sort_by_tag
   // record input
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [msort_pkg::RecW-1:0]  req_tdata,   // key[31:0], tag[47:32]
   input  logic                        req_tlast,   // last
   // sorted output
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [msort_pkg::RecW-1:0]  rsp_tdata,   // sorted_key[31:0], sorted_tag[47:32]
   output logic                        rsp_tlast,   // last_out
   output logic                        rsp_tuser    // dropped
);

   msort_pkg::cmd_type    cmd;
   msort_pkg::status_type status;

   // Register write is always taken
   assign csr_ready = 1'b1;

   msort_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid)
   );

   msort_dpath #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .csr_valid   (csr_valid),
      .csr_wdata   (csr_wdata),
      .req_rec     (req_tdata),
      .status      (status),
      .rsp_rec     (rsp_tdata),
      .rsp_last    (rsp_tlast),
      .rsp_dropped (rsp_tuser)
   );

endmodule
